// File: rtl/ssve_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssve_pkg
// Shared types, codes and constants of the slice sampler voice engine.
// ----------------------------------------------------------------------------
package ssve_pkg;

	localparam int VOICE_COUNT_DEF = 16;
	localparam int SLICE_DEPTH_DEF = 128;
	localparam int PCM_FRAMES_DEF  = 65536;

	localparam logic [7:0]  NOTE_BASE   = 8'd36;
	localparam logic [3:0]  ST_NOTE_ON  = 4'h9;
	localparam logic [3:0]  ST_CTRL     = 4'hB;
	localparam logic [7:0]  CC_ALL_OFF  = 8'd123;
	localparam logic [15:0] GAIN_MAX    = 16'd32768;

	typedef enum logic [2:0] {
		OP_MIDI  = 3'd0,
		OP_TICK  = 3'd1,
		OP_SLICE = 3'd2,
		OP_PCM   = 3'd3,
		OP_PANIC = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_GAIN   = 3'd0,
		REG_STEREO = 3'd1,
		REG_TOTAL  = 3'd2,
		REG_SCOUNT = 3'd3,
		REG_LOADED = 3'd4
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NOTE_RD,
		S_NOTE_CHK,
		S_NOTE_SCAN,
		S_NOTE_SET,
		S_TICK_VOICE,
		S_TICK_SLRD,
		S_TICK_POS,
		S_TICK_PCM,
		S_TICK_SCALE,
		S_TICK_MIX,
		S_TICK_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture input item
		logic slice_wr;
		logic pcm_wr;
		logic silence;
		logic slice_rd;   // read slice table at note slice or voice slice
		logic rd_voice;   // slice read address from current voice
		logic scan_clr;
		logic scan_step;
		logic note_set;
		logic vsel_clr;
		logic vsel_next;
		logic pos_calc;
		logic pcm_rd;
		logic kill;
		logic scale;
		logic mix;
		logic mix_clr;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic note_ok;     // note-on in range, slice index ok
		logic note_nz;     // slice length nonzero
		logic clear_cc;    // controller 123
		logic scan_done;
		logic v_active;
		logic v_last;
		logic pos_ok;
	} stat_t;

	function automatic logic signed [15:0] clamp16(input logic signed [33:0] v);
		if (v > 34'sd32767) return 16'sh7fff;
		else if (v < -34'sd32768) return 16'sh8000;
		else return v[15:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/ssve_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssve_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ssve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: rtl/ssve_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssve_ctrl
// Sequencer: decodes an item and steps the datapath through it.
// ----------------------------------------------------------------------------
module ssve_ctrl
	import ssve_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] op,
	input  wire logic       loaded,
	input  wire stat_t      st,
	output logic            busy,
	output cmd_t            cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					case (op_t'(op))
						OP_MIDI:  state_d = S_NOTE_RD;
						OP_TICK: begin
							cmd.vsel_clr = 1'b1;
							cmd.mix_clr  = 1'b1;
							state_d = loaded ? S_TICK_VOICE : S_TICK_OUT;
						end
						OP_SLICE: cmd.slice_wr = 1'b1;
						OP_PCM:   cmd.pcm_wr   = 1'b1;
						OP_PANIC: cmd.silence  = 1'b1;
						default: ;
					endcase
				end
			end
			S_NOTE_RD: begin
				cmd.slice_rd = 1'b1;
				cmd.scan_clr = 1'b1;
				if (st.clear_cc) begin
					cmd.silence = 1'b1;
					state_d = S_IDLE;
				end else if (st.note_ok) begin
					state_d = S_NOTE_CHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_NOTE_CHK: state_d = st.note_nz ? S_NOTE_SCAN : S_IDLE;
			S_NOTE_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_done) state_d = S_NOTE_SET;
			end
			S_NOTE_SET: begin
				cmd.note_set = 1'b1;
				state_d = S_IDLE;
			end
			S_TICK_VOICE: begin
				if (st.v_active) begin
					cmd.slice_rd = 1'b1;
					cmd.rd_voice = 1'b1;
					state_d = S_TICK_SLRD;
				end else if (st.v_last) begin
					state_d = S_TICK_OUT;
				end else begin
					cmd.vsel_next = 1'b1;
				end
			end
			S_TICK_SLRD: begin
				cmd.slice_rd = 1'b1;
				cmd.rd_voice = 1'b1;
				state_d = S_TICK_POS;
			end
			S_TICK_POS: begin
				cmd.pos_calc = 1'b1;
				state_d = S_TICK_PCM;
			end
			S_TICK_PCM: begin
				if (st.pos_ok) begin
					cmd.pcm_rd = 1'b1;
					state_d = S_TICK_SCALE;
				end else begin
					cmd.kill = 1'b1;
					if (st.v_last) state_d = S_TICK_OUT;
					else begin
						cmd.vsel_next = 1'b1;
						state_d = S_TICK_VOICE;
					end
				end
			end
			S_TICK_SCALE: begin
				cmd.scale = 1'b1;
				state_d = S_TICK_MIX;
			end
			S_TICK_MIX: begin
				cmd.mix = 1'b1;
				if (st.v_last) state_d = S_TICK_OUT;
				else begin
					cmd.vsel_next = 1'b1;
					state_d = S_TICK_VOICE;
				end
			end
			S_TICK_OUT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("emit not followed by idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_TICK) |-> ##1 busy)
		else $error("tick not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.note_set) |-> $past(state_q) == S_NOTE_SCAN)
		else $error("note set without scan");
endmodule
`default_nettype wire

// File: rtl/ssve_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssve_datapath
// Voice registers, slice table, PCM store, age scan and mixer.
// ----------------------------------------------------------------------------
module ssve_datapath
	import ssve_pkg::*;
#(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF,
	parameter int SLICE_DEPTH = SLICE_DEPTH_DEF,
	parameter int PCM_FRAMES  = PCM_FRAMES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   st,
	input  wire logic [15:0]        gain_q14,
	input  wire logic               stereo_mode,
	input  wire logic [16:0]        total_frames,
	input  wire logic [7:0]         num_slices,
	input  wire logic [7:0]         midi_status,
	input  wire logic [7:0]         midi_data1,
	input  wire logic [7:0]         midi_data2,
	input  wire logic [1:0]         midi_length,
	input  wire logic [6:0]         load_slice_index,
	input  wire logic [15:0]        load_slice_offset,
	input  wire logic [16:0]        load_slice_length,
	input  wire logic [15:0]        pcm_address,
	input  wire logic signed [15:0] pcm_left,
	input  wire logic signed [15:0] pcm_right,
	output logic signed [15:0]      out_left,
	output logic signed [15:0]      out_right
);
	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int SW = (SLICE_DEPTH > 1) ? $clog2(SLICE_DEPTH) : 1;
	localparam int PW = $clog2(PCM_FRAMES);
	localparam logic [20:0] PCM_END = 21'(PCM_FRAMES);
	localparam logic [7:0]  SLICE_LIM = 8'(SLICE_DEPTH);

	// latched item
	logic [7:0]  status_q, d1_q, d2_q;
	logic [1:0]  len_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			status_q <= midi_status;
			d1_q     <= midi_data1;
			d2_q     <= midi_data2;
			len_q    <= midi_length;
		end
	end

	// voices
	logic [VOICE_COUNT-1:0] act_q;
	logic [6:0]  vslice_q [VOICE_COUNT];
	logic [16:0] vpos_q   [VOICE_COUNT];
	logic [31:0] vage_q   [VOICE_COUNT];
	logic [31:0] agec_q;
	logic [VW-1:0] vsel_q;
	logic [VW:0]   scan_q;
	logic [VW-1:0] best_q;
	logic [31:0]   oldest_q;
	logic          found_q;

	// note decode
	logic [7:0] sl8;
	logic [7:0] limit;
	logic       vel_nz;
	always_comb begin
		sl8    = d1_q - NOTE_BASE;
		limit  = (num_slices < SLICE_LIM) ? num_slices : SLICE_LIM;
		vel_nz = (len_q == 2'd3) && (d2_q != 8'd0);
		st.note_ok  = (len_q >= 2'd2) && (status_q[7:4] == ST_NOTE_ON) && vel_nz
			&& (d1_q >= NOTE_BASE) && (sl8 < limit);
		st.clear_cc = (len_q >= 2'd2) && (status_q[7:4] == ST_CTRL) && !vel_nz
			&& (d1_q == CC_ALL_OFF) || ((len_q >= 2'd2) && (status_q[7:4] == ST_CTRL)
			&& (d1_q == CC_ALL_OFF));
	end

	// slice table
	logic [SW-1:0] sl_addr;
	logic [32:0]   sl_rd;
	logic [6:0]    vs7;
	assign vs7 = vslice_q[vsel_q];
	always_comb begin
		if (cmd.slice_wr) sl_addr = load_slice_index[SW-1:0];
		else if (cmd.rd_voice) sl_addr = vs7[SW-1:0];
		else sl_addr = sl8[SW-1:0];
	end
	logic slice_we;
	assign slice_we = cmd.slice_wr && ({1'b0, load_slice_index} < SLICE_LIM);

	ssve_ram #(.WIDTH(33), .DEPTH(SLICE_DEPTH)) u_slice (
		.clk(clk), .we(slice_we), .addr(sl_addr),
		.wdata({load_slice_length, load_slice_offset}), .rdata(sl_rd)
	);
	assign st.note_nz = (sl_rd[32:16] != 17'd0);

	// pcm store
	logic [20:0] pos_s1, end_s1;
	logic [PW-1:0] pcm_addr;
	logic [31:0]   pcm_rd;
	logic          pcm_we;
	assign pcm_we   = cmd.pcm_wr && ({5'd0, pcm_address} < PCM_END);
	assign pcm_addr = cmd.pcm_wr ? PW'(pcm_address) : pos_s1[PW-1:0];

	ssve_ram #(.WIDTH(32), .DEPTH(PCM_FRAMES)) u_pcm (
		.clk(clk), .we(pcm_we), .addr(pcm_addr),
		.wdata({pcm_right, pcm_left}), .rdata(pcm_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.pos_calc) begin
			pos_s1 <= {5'd0, sl_rd[15:0]} + {4'd0, vpos_q[vsel_q]};
			end_s1 <= {5'd0, sl_rd[15:0]} + {4'd0, sl_rd[32:16]};
		end
	end
	assign st.pos_ok = (pos_s1 < end_s1) && (pos_s1 < {4'd0, total_frames})
		&& (pos_s1 < PCM_END);

	// scaling
	logic [15:0] g;
	logic signed [33:0] pl_s2, pr_s2;
	logic signed [15:0] sl_l, sl_r;
	logic signed [15:0] mixl_q, mixr_q;
	assign g = (gain_q14 > GAIN_MAX) ? GAIN_MAX : gain_q14;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			pl_s2 <= 34'($signed(pcm_rd[15:0]) * $signed({1'b0, g}));
			pr_s2 <= 34'($signed(pcm_rd[31:16]) * $signed({1'b0, g}));
		end
	end

	function automatic logic signed [15:0] div14(input logic signed [33:0] p);
		logic signed [33:0] q;
		q = (p < 0) ? -((-p) >>> 14) : (p >>> 14);
		return clamp16(q);
	endfunction

	assign sl_l = div14(pl_s2);
	assign sl_r = stereo_mode ? div14(pr_s2) : sl_l;

	assign st.v_active = act_q[vsel_q];
	assign st.v_last   = (vsel_q == VW'(VOICE_COUNT - 1));
	assign st.scan_done = (scan_q == (VW+1)'(VOICE_COUNT - 1)) || !act_q[scan_q[VW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			agec_q <= '0;
			vsel_q <= '0;
			scan_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				vslice_q[i] <= '0;
				vpos_q[i]   <= '0;
				vage_q[i]   <= '0;
			end
		end else begin
			if (cmd.silence) act_q <= '0;
			if (cmd.vsel_clr) vsel_q <= '0;
			if (cmd.vsel_next) vsel_q <= vsel_q + 1'b1;
			if (cmd.kill) act_q[vsel_q] <= 1'b0;
			if (cmd.mix) vpos_q[vsel_q] <= vpos_q[vsel_q] + 17'd1;
			if (cmd.scan_clr) scan_q <= '0;
			if (cmd.scan_step) scan_q <= scan_q + 1'b1;
			if (cmd.note_set) begin
				agec_q <= agec_q + 32'd1;
				act_q[best_q]    <= 1'b1;
				vslice_q[best_q] <= sl8[6:0];
				vpos_q[best_q]   <= '0;
				vage_q[best_q]   <= agec_q + 32'd1;
			end
		end
	end

	// free-or-oldest voice scan, one voice a cycle: first free voice wins, else oldest (lowest index on a tie)
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			best_q   <= '0;
			oldest_q <= '1;
			found_q  <= 1'b0;
		end else if (cmd.scan_step && !found_q) begin
			if (!act_q[scan_q[VW-1:0]]) begin
				best_q  <= scan_q[VW-1:0];
				found_q <= 1'b1;
			end else if (vage_q[scan_q[VW-1:0]] < oldest_q) begin
				oldest_q <= vage_q[scan_q[VW-1:0]];
				best_q   <= scan_q[VW-1:0];
			end
		end
	end

	// mixer
	always_ff @(posedge clk) begin
		if (cmd.mix_clr) begin
			mixl_q <= '0;
			mixr_q <= '0;
		end else if (cmd.mix) begin
			mixl_q <= clamp16(34'(mixl_q) + 34'(sl_l));
			mixr_q <= clamp16(34'(mixr_q) + 34'(sl_r));
		end
	end

	assign out_left  = mixl_q;
	assign out_right = mixr_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.note_set |=> act_q[$past(best_q)])
		else $error("stolen voice not active");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.silence |=> act_q == '0)
		else $error("silence left a voice");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |-> $past(cmd.scale))
		else $error("mix without scale");
endmodule
`default_nettype wire

// File: rtl/slice_sampler_voice_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slice_sampler_voice_engine
// 16-voice one-shot slice player with oldest-voice stealing.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  item in  | start & !busy           | op, midi_*, load_slice_*, pcm_*
//  result   | done strobe, one cycle  | out_left, out_right
//  config   | APB psel/penable/pwrite | paddr, pwdata, prdata
//
//  Loads and panic complete as the item is taken, in S_IDLE; a MIDI item
//  reads the slice table, checks it, then runs the one-voice-a-cycle free-or-oldest scan. A
//  tick reads slice table and PCM store and scales each active voice, then emits.
//  Reset clears voices, age counter and registers; stores are undefined.
//  done cannot be stalled.
// ----------------------------------------------------------------------------
module slice_sampler_voice_engine
	import ssve_pkg::*;
#(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF,
	parameter int SLICE_DEPTH = SLICE_DEPTH_DEF,
	parameter int PCM_FRAMES  = PCM_FRAMES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	input  wire logic [2:0]         op,
	input  wire logic [7:0]         midi_status,
	input  wire logic [7:0]         midi_data1,
	input  wire logic [7:0]         midi_data2,
	input  wire logic [1:0]         midi_length,
	input  wire logic [6:0]         load_slice_index,
	input  wire logic [15:0]        load_slice_offset,
	input  wire logic [16:0]        load_slice_length,
	input  wire logic [15:0]        pcm_address,
	input  wire logic signed [15:0] pcm_left,
	input  wire logic signed [15:0] pcm_right,
	output logic signed [15:0]      out_left,
	output logic signed [15:0]      out_right,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	logic [15:0] gain_q;
	logic        stereo_q, loaded_q;
	logic [16:0] total_q;
	logic [7:0]  scount_q;
	logic        wr;
	cmd_t        cmd;
	stat_t       st;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd16384;
			stereo_q <= 1'b0;
			total_q  <= '0;
			scount_q <= '0;
			loaded_q <= 1'b0;
		end else if (wr && paddr[1:0] == 2'd0) begin
			unique case (paddr[4:2])
				REG_GAIN:   gain_q   <= pwdata[15:0];
				REG_STEREO: stereo_q <= pwdata[0];
				REG_TOTAL:  total_q  <= pwdata[16:0];
				REG_SCOUNT: scount_q <= pwdata[7:0];
				REG_LOADED: loaded_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_GAIN:   prdata = {16'd0, gain_q};
			REG_STEREO: prdata = {31'd0, stereo_q};
			REG_TOTAL:  prdata = {15'd0, total_q};
			REG_SCOUNT: prdata = {24'd0, scount_q};
			REG_LOADED: prdata = {31'd0, loaded_q};
			default:    prdata = '0;
		endcase
	end

	ssve_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.loaded(loaded_q), .st(st), .busy(busy), .cmd(cmd)
	);

	ssve_datapath #(
		.VOICE_COUNT(VOICE_COUNT), .SLICE_DEPTH(SLICE_DEPTH), .PCM_FRAMES(PCM_FRAMES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.gain_q14(gain_q), .stereo_mode(stereo_q), .total_frames(total_q),
		.num_slices(scount_q),
		.midi_status(loaded_q ? midi_status : 8'd0), .midi_data1(midi_data1),
		.midi_data2(midi_data2), .midi_length(midi_length),
		.load_slice_index(load_slice_index), .load_slice_offset(load_slice_offset),
		.load_slice_length(load_slice_length), .pcm_address(pcm_address),
		.pcm_left(pcm_left), .pcm_right(pcm_right),
		.out_left(out_left), .out_right(out_right)
	);

	assign done = cmd.emit;
endmodule
`default_nettype wire
